@@ design/ipv4ft_pkg.sv @@
// Shared types and constants for the IPv4 five-tuple extractor.
package ipv4ft_pkg;

  localparam int unsigned COUNT_W = 16;

  localparam logic [3:0]         VERSION_IPV4   = 4'd4;
  localparam logic [3:0]         MIN_IHL        = 4'd5;
  localparam logic [7:0]         PROTO_TCP      = 8'd6;
  localparam logic [7:0]         PROTO_UDP      = 8'd17;
  localparam logic [COUNT_W-1:0] MIN_PACKET_LEN = 16'd20;
  localparam logic [COUNT_W-1:0] PORT_BYTES     = 16'd4;

  // Header fields gathered so far for the packet in flight.
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [3:0]         version;
    logic [3:0]         header_words;
    logic [15:0]        total_length;
    logic [7:0]         protocol;
    logic [31:0]        src_addr;
    logic [31:0]        dst_addr;
    logic [15:0]        source_port;
    logic [15:0]        dest_port;
  } fields_t;

endpackage

@@ design/ipv4_five_tuple_extractor.sv @@
// Top level of the IPv4 five-tuple extractor.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one packet byte per request in
//   wire order; last_byte marks the final byte. Output channel
//   (out_valid/out_ready) carries one result per packet: accepted, protocol,
//   both addresses and, for TCP or UDP, both ports. Rejected packets give an
//   all-zero result.
//   Throughput: one byte per cycle, sustained, while the receiver takes
//   results. Each byte costs a counter compare and a field capture; the final
//   byte also runs the length and header checks in the same cycle.
//   Latency: the result is valid the cycle after the final byte is accepted.
//   The result register holds one finished result; while it waits and the
//   receiver stalls (out_ready low), in_ready drops and input holds. A result
//   taken in the same cycle frees the register, so packets may run back to
//   back with no gap.
//   The byte count saturates at MAX_PACKET_LEN; all captured bytes lie below
//   index 64, so with MAX_PACKET_LEN of at least 64 saturation never disturbs the fields.
//   Reset (rst, synchronous) clears the counter, every captured field and the
//   result valid flag; the first byte after reset starts a new packet.
module ipv4_five_tuple_extractor #(
  parameter int unsigned MAX_PACKET_LEN = 65535
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        accepted,
  output logic [7:0]  protocol,
  output logic [31:0] src_addr,
  output logic [31:0] dst_addr,
  output logic [15:0] source_port,
  output logic [15:0] dest_port
);

  ipv4ft_pkg::fields_t fields_next;
  logic                in_fire;

  // Advance input whenever the result register is empty or being drained.
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  ipv4ft_capture #(
    .MAX_PACKET_LEN(MAX_PACKET_LEN)
  ) u_capture (
    .clk        (clk),
    .rst        (rst),
    .fire       (in_fire),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .fields_next(fields_next)
  );

  // Load the result register on the final byte of each packet.
  ipv4ft_result u_result (
    .clk        (clk),
    .rst        (rst),
    .load       (in_fire && last_byte),
    .fields_next(fields_next),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .accepted   (accepted),
    .protocol   (protocol),
    .src_addr   (src_addr),
    .dst_addr   (dst_addr),
    .source_port(source_port),
    .dest_port  (dest_port)
  );

endmodule

@@ design/ipv4ft_capture.sv @@
// Byte counter and header field capture for the IPv4 five-tuple extractor.
module ipv4ft_capture #(
  parameter int unsigned MAX_PACKET_LEN = 65535
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  output ipv4ft_pkg::fields_t fields_next
);

  localparam logic [ipv4ft_pkg::COUNT_W-1:0] MaxLen = ipv4ft_pkg::COUNT_W'(MAX_PACKET_LEN);

  ipv4ft_pkg::fields_t              fields;
  logic [ipv4ft_pkg::COUNT_W-1:0]   idx;
  logic [ipv4ft_pkg::COUNT_W-1:0]   hlen;

  assign idx  = fields.count;
  assign hlen = ipv4ft_pkg::COUNT_W'({fields.header_words, 2'b00});

  always_comb begin
    fields_next = fields;
    if (idx < MaxLen) begin
      fields_next.count = idx + 1'b1;
      if (idx == '0) begin
        fields_next.version      = data_byte[7:4];
        fields_next.header_words = data_byte[3:0];
      end else begin
        if (idx == 16'd2) fields_next.total_length[15:8] = data_byte;
        if (idx == 16'd3) fields_next.total_length[7:0]  = data_byte;
        if (idx == 16'd9) fields_next.protocol = data_byte;
        if (idx >= 16'd12 && idx <= 16'd15) begin
          fields_next.src_addr = {fields.src_addr[23:0], data_byte};
        end
        if (idx >= 16'd16 && idx <= 16'd19) begin
          fields_next.dst_addr = {fields.dst_addr[23:0], data_byte};
        end
        // Ports follow the variable-length header.
        if (idx == hlen || idx == hlen + 16'd1) begin
          fields_next.source_port = {fields.source_port[7:0], data_byte};
        end
        if (idx == hlen + 16'd2 || idx == hlen + 16'd3) begin
          fields_next.dest_port = {fields.dest_port[7:0], data_byte};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fields <= '0;
    end else if (fire) begin
      if (last_byte) begin
        fields <= '0;
      end else begin
        fields <= fields_next;
      end
    end
  end

endmodule

@@ design/ipv4ft_result.sv @@
// Acceptance check and result register for the IPv4 five-tuple extractor.
module ipv4ft_result (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  ipv4ft_pkg::fields_t fields_next,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                accepted,
  output logic [7:0]          protocol,
  output logic [31:0]         src_addr,
  output logic [31:0]         dst_addr,
  output logic [15:0]         source_port,
  output logic [15:0]         dest_port
);

  logic [ipv4ft_pkg::COUNT_W-1:0] n;
  logic [ipv4ft_pkg::COUNT_W-1:0] hlen;
  logic                           ported;
  logic                           ok;
  logic                           out_valid_next;

  assign n      = fields_next.count;
  assign hlen   = ipv4ft_pkg::COUNT_W'({fields_next.header_words, 2'b00});
  assign ported = (fields_next.protocol == ipv4ft_pkg::PROTO_TCP) ||
                  (fields_next.protocol == ipv4ft_pkg::PROTO_UDP);

  always_comb begin
    ok = (n >= ipv4ft_pkg::MIN_PACKET_LEN) &&
         (fields_next.version == ipv4ft_pkg::VERSION_IPV4) &&
         (fields_next.header_words >= ipv4ft_pkg::MIN_IHL) &&
         (n >= hlen) && (fields_next.total_length >= hlen);
    // hlen is at most 60, so the sum cannot wrap.
    if (ported && n < hlen + ipv4ft_pkg::PORT_BYTES) ok = 1'b0;
  end

  always_comb begin
    out_valid_next = out_valid;
    if (load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      accepted    <= ok;
      protocol    <= ok ? fields_next.protocol : 8'd0;
      src_addr    <= ok ? fields_next.src_addr : 32'd0;
      dst_addr    <= ok ? fields_next.dst_addr : 32'd0;
      source_port <= (ok && ported) ? fields_next.source_port : 16'd0;
      dest_port   <= (ok && ported) ? fields_next.dest_port : 16'd0;
    end
  end

endmodule
